FILE: sv/mkpm_pkg.sv
// Shared types and constants of the multi-keyword prefix matcher.
package mkpm_pkg;

  localparam int NumKeysDef  = 4;
  localparam int KeyBytesDef = 8;
  localparam int KeyRegs     = 4;  // keyword registers on the config port
  localparam int KeyCountW   = 3;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;

  localparam logic [CfgIdxW-1:0] CfgKeyCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd1;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;

  typedef enum logic [1:0] {
    StatusEol    = 2'd0,
    StatusFound  = 2'd1,
    StatusSearch = 2'd2
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_in;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] key_index;
    logic [2:0] remaining;
  } res_t;

endpackage

FILE: sv/mkpm_req_if.sv
// Request channel: valid/ready handshake carrying a command or character.
interface mkpm_req_if import mkpm_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/mkpm_res_if.sv
// Result channel: valid/ready handshake carrying one match result.
interface mkpm_res_if import mkpm_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/multi_keyword_prefix_matcher_core.sv
// Multi-keyword prefix matcher: parallel compare of all keys per character.
//
//   channel   dir  handshake            payload
//   in_req_i  in   valid/ready          cmd, char_in
//   out_res_o out  valid/ready          status, key_index, remaining
//   cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// One request per cycle unless the request port stalls. A request is registered
// in the input register, compared against every key combinationally, and its
// result is then registered in the output register, from which the sink takes
// it. A restart request updates the state and gives no result.
// Reset clears the keys, key count, candidates and position. A stalled output
// holds the next request in the input register; the request port stalls only
// when both registers are full.
module multi_keyword_prefix_matcher_core import mkpm_pkg::*; #(
  parameter int NUM_KEYS  = NumKeysDef,
  parameter int KEY_BYTES = KeyBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mkpm_req_if.sink             in_req_i,
  mkpm_res_if.source           out_res_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int NumWords = (NUM_KEYS < KeyRegs) ? NUM_KEYS : KeyRegs;
  localparam int KeyW     = KEY_BYTES * 8;
  localparam int PosW     = $clog2(KEY_BYTES + 1);

  function automatic logic [7:0] key_byte(logic [KeyW-1:0] word, logic [PosW:0] pos);
    logic [7:0] b;
    b = '0;
    for (int j = 0; j < KEY_BYTES; j++) begin
      if (pos == (PosW+1)'(j)) b = word[j*8 +: 8];
    end
    return b;
  endfunction

  // configuration
  logic [KeyCountW-1:0] key_count_q;
  logic [KeyW-1:0]      key_q [NumWords];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      for (int k = 0; k < NumWords; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgKeyCount) key_count_q <= cfg_data_i[KeyCountW-1:0];
      for (int k = 0; k < NumWords; k++) begin
        if (cfg_idx_i == CfgKeyWord0 + CfgIdxW'(k)) key_q[k] <= cfg_data_i[KeyW-1:0];
      end
    end
  end

  // match state
  logic [NUM_KEYS-1:0] mask_q, mask_d;
  logic [PosW-1:0]     pos_q, pos_d;

  // input register
  logic s1_valid_q, s1_valid_d;
  req_t s1_req_q;
  logic s1_fire, in_acc;

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_res_q, res_d;

  assign s1_fire         = s1_valid_q && (s1_req_q.cmd || !out_valid_q || out_res_o.ready);
  assign in_req_i.ready  = !s1_valid_q || s1_fire;
  assign in_acc          = in_req_i.valid && in_req_i.ready;
  assign s1_valid_d      = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  // compare stage
  logic [KeyCountW-1:0] n_eff;
  logic [NUM_KEYS-1:0]  active, hit, done, new_mask, restart_mask;
  logic [KeyW-1:0]      word;
  logic [PosW:0]        pos_cur, pos_nxt;
  logic                 found, is_eol;
  logic [1:0]           found_idx;
  logic [2:0]           remaining;

  always_comb begin
    n_eff   = (key_count_q > KeyCountW'(NUM_KEYS)) ? KeyCountW'(NUM_KEYS) : key_count_q;
    pos_cur = {1'b0, pos_q};
    pos_nxt = pos_cur + 1'b1;
    is_eol  = s1_req_q.char_in inside {ChNul, ChLf, ChCr};
    for (int i = 0; i < NUM_KEYS; i++) begin
      word            = (i < NumWords) ? key_q[i % NumWords] : '0;
      restart_mask[i] = KeyCountW'(i) < n_eff;
      active[i]       = mask_q[i] && restart_mask[i];
      hit[i]          = active[i] && (key_byte(word, pos_cur) == s1_req_q.char_in);
      done[i]         = hit[i] && (key_byte(word, pos_nxt) == 8'h00);
    end
    // walk keys in order; the first finished key stops further drops
    found     = 1'b0;
    found_idx = '0;
    remaining = '0;
    new_mask  = mask_q;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (!found && active[i] && !hit[i]) new_mask[i] = 1'b0;
      if (!found && done[i]) begin
        found     = 1'b1;
        found_idx = 2'(i);
      end
      if (hit[i] && !done[i]) remaining = remaining + 3'd1;
    end

    mask_d = mask_q;
    pos_d  = pos_q;
    res_d  = '{status: StatusEol, key_index: 2'd0, remaining: 3'd0};
    if (s1_req_q.cmd) begin
      mask_d = restart_mask;
      pos_d  = '0;
    end else if (!is_eol) begin
      mask_d = new_mask;
      if (found) begin
        res_d.status    = StatusFound;
        res_d.key_index = found_idx;
      end else begin
        res_d.status    = StatusSearch;
        res_d.remaining = remaining;
        if (pos_q < PosW'(KEY_BYTES)) pos_d = pos_q + 1'b1;
      end
    end
  end

  assign out_valid_d = (s1_fire && !s1_req_q.cmd) ? 1'b1 :
                       (out_res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
      pos_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        mask_q <= mask_d;
        pos_q  <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_req_q <= in_req_i.payload;
    if (s1_fire && !s1_req_q.cmd) out_res_q <= res_d;
  end

  assign out_res_o.valid   = out_valid_q;
  assign out_res_o.payload = out_res_q;

endmodule

FILE: sv/mkpm_checker.sv
// Port-level checks of the matcher core, bound to the top level.
module mkpm_checker import mkpm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input res_t out_payload_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // the request port only stalls behind a blocked result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("request port stalled with result side free");

  // a fresh result follows an accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result without matching request");

endmodule

bind multi_keyword_prefix_matcher_core mkpm_checker u_mkpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_req_i.valid),
  .in_ready_i    (in_req_i.ready),
  .out_valid_i   (out_res_o.valid),
  .out_ready_i   (out_res_o.ready),
  .out_payload_i (out_res_o.payload)
);

FILE: test/tb_multi_keyword_prefix_matcher_core.sv
// Testbench for multi_keyword_prefix_matcher_core: directed table, then random keyword phases.
module tb_multi_keyword_prefix_matcher_core;
  import mkpm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgKeyWord0 + CfgIdxW'(KeyRegs);  // first unused
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = '1;

  localparam req_t Restart = '{1'b1, 8'h00};
  localparam req_t ChA     = '{1'b0, 8'h61};
  localparam req_t ChB     = '{1'b0, 8'h62};
  localparam req_t ChX     = '{1'b0, 8'h78};
  localparam req_t ChTop   = '{1'b0, 8'hFF};
  localparam req_t ReqNul  = '{1'b0, ChNul};
  localparam req_t ReqLf   = '{1'b0, ChLf};
  localparam req_t ReqCr   = '{1'b0, ChCr};

  localparam res_t ResEol    = '{StatusEol, 2'd0, 3'd0};
  localparam res_t ResNoCand = '{StatusSearch, 2'd0, 3'd0};

  localparam int DirRows   = 25;
  localparam int KeysRow   = 5;  // keys are loaded before this row
  localparam int PhaseReqs = 130;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t res;
  } dir_row_t;

  // rows before KeysRow run on the reset state: no keys, key_count 0
  dir_row_t dir_rows [DirRows] = '{
    '{Restart, 1'b0, ResEol},
    '{ChA,     1'b1, ResNoCand},
    '{ReqNul,  1'b1, ResEol},
    '{ReqLf,   1'b1, ResEol},
    '{ReqCr,   1'b1, ResEol},
    // keys: "ax", "ab", eight 0xFF bytes, empty
    '{Restart, 1'b0, ResEol},
    '{ChA,     1'b0, ResEol},
    '{ChB,     1'b0, ResEol},  // key 1 found, key 0 dropped on the way
    '{ChX,     1'b0, ResEol},  // key 0 must stay dropped
    '{Restart, 1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},
    '{ChTop,   1'b0, ResEol},  // full-width key found on its last byte
    '{ChTop,   1'b0, ResEol},
    '{Restart, 1'b0, ResEol},
    '{ChA,     1'b0, ResEol},
    '{ReqNul,  1'b1, ResEol},
    '{ReqLf,   1'b1, ResEol},
    '{ReqCr,   1'b1, ResEol},
    '{ChB,     1'b0, ResEol}   // line ends left the search state alone
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mkpm_req_if req_ch ();
  mkpm_res_if res_ch ();

  multi_keyword_prefix_matcher_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (req_ch),
    .out_res_o  (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [2:0]            key_cnt;
  logic [CfgDataW-1:0]   key_word [KeyRegs];
  logic [NumKeysDef-1:0] cand_mask;
  logic [3:0]            match_pos;

  res_t expected_res_q [$];
  int   err_count   = 0;
  int   n_results   = 0;
  int   items_sent  = 0;
  bit   calm        = 1'b0;  // no random idling on either side
  int   hold_at     = 150;
  int   hold_left   = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [7:0] key_at(input int k, input int p);
    if (p >= KeyBytesDef) return 8'h00;
    return key_word[k][8*p +: 8];
  endfunction

  function automatic void apply_key_reg(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    if (idx == CfgKeyCount) key_cnt = data[2:0];
    else if (idx >= CfgKeyWord0 && idx < CfgIdxSpare) key_word[2'(idx - CfgKeyWord0)] = data;
  endfunction

  // Updates the search state; returns 1 when the request produces a result.
  function automatic bit predict_match(input req_t r, output res_t res);
    int n;
    int rem;
    n   = (key_cnt > NumKeysDef) ? NumKeysDef : key_cnt;
    rem = 0;
    res = ResEol;
    if (r.cmd) begin
      cand_mask = '0;
      for (int i = 0; i < n; i++) cand_mask[i] = 1'b1;
      match_pos = '0;
      return 1'b0;
    end
    if (r.char_in == ChNul || r.char_in == ChLf || r.char_in == ChCr) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!cand_mask[i]) continue;
      if (key_at(i, match_pos) != r.char_in) begin
        cand_mask[i] = 1'b0;
      end else if (key_at(i, match_pos + 1) == 8'h00) begin
        res.status    = StatusFound;
        res.key_index = i[1:0];
        return 1'b1;
      end else begin
        rem++;
      end
    end
    if (match_pos < KeyBytesDef) match_pos++;
    res.status    = StatusSearch;
    res.remaining = rem[2:0];
    return 1'b1;
  endfunction

  // Called at a falling edge, returns at a falling edge.
  task automatic send_req(input req_t r, input bit typed = 1'b0, input res_t typed_res = '0);
    res_t res;
    while (!calm && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    if (predict_match(r, res)) expected_res_q.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    apply_key_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drain: all results in, then let trailing restarts settle
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(1, 255));
    return 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] pick_eol();
    case ($urandom_range(0, 2))
      0:       return ChNul;
      1:       return ChLf;
      default: return ChCr;
    endcase
  endfunction

  // Random key; with a nonzero base it often shares a prefix with it.
  function automatic logic [63:0] make_key(input logic [63:0] base);
    int len;
    int share;
    logic [63:0] w;
    len   = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    share = $urandom_range(0, 1) ? $urandom_range(0, len) : 0;
    w     = '0;
    for (int j = 0; j < 8; j++) begin
      if (j < len)
        w[8*j +: 8] = (j < share && base[8*j +: 8] != 0) ? base[8*j +: 8] : pick_char();
      else if (j > len && $urandom_range(0, 3) == 0)
        w[8*j +: 8] = 8'($urandom);  // junk after the terminator
    end
    return w;
  endfunction

  task automatic run_phase(input logic [2:0] cnt, input bit quiet);
    int start;
    int act;
    int k;
    int plen;
    int r;
    logic [7:0] c;
    logic [63:0] w0;
    calm  = quiet;
    start = items_sent;
    act   = (cnt > NumKeysDef) ? NumKeysDef : cnt;
    w0    = make_key('0);
    write_key_reg(CfgKeyCount, CfgDataW'(cnt));
    write_key_reg(CfgKeyWord0, w0);
    for (int i = 1; i < KeyRegs; i++)
      write_key_reg(CfgKeyWord0 + CfgIdxW'(i), make_key(w0));
    if ($urandom_range(0, 1)) write_key_reg(CfgIdxSpare + CfgIdxW'($urandom_range(0, 2)),
                                             {$urandom, $urandom});
    @(negedge clk_i);
    while (items_sent - start < PhaseReqs) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 8)) send_req('{1'b0, 8'($urandom_range(0, 255))});
        end
        8: send_req('{1'b0, pick_eol()});
        9: begin
          send_req('{1'b1, 8'($urandom)});
          send_req('{1'b0, 8'($urandom)});
        end
        default: begin
          // restart, then follow one key for a while
          send_req('{1'b1, 8'($urandom)});
          k    = (act > 0) ? $urandom_range(0, act - 1) : $urandom_range(0, KeyRegs - 1);
          plen = $urandom_range(1, 9);
          for (int j = 0; j < plen; j++) begin
            c = (j < 8 && key_word[k][8*j +: 8] != 0) ? key_word[k][8*j +: 8] : pick_char();
            r = $urandom_range(0, 19);
            if (r == 0) c = pick_eol();
            else if (r == 1) c = 8'($urandom_range(0, 255));
            send_req('{1'b0, c});
          end
        end
      endcase
    end
    quiesce();
    calm = 1'b0;
  endtask

  // result side: random stalls plus long hold-offs that back up the request side
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (n_results >= hold_at) begin
        hold_left = 60;
        hold_at  += 350;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      n_results++;
      if (expected_res_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                  got.status, got.key_index, got.remaining));
      end else begin
        want = expected_res_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.key_index !== want.key_index)
          report_mismatch($sformatf("key_index %0d, want %0d", got.key_index, want.key_index));
        if (got.remaining !== want.remaining)
          report_mismatch($sformatf("remaining %0d, want %0d", got.remaining, want.remaining));
      end
    end
  end

  initial begin
    #3000000;
    $display("[multi_keyword_prefix_matcher_core] ERROR");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    key_cnt        = '0;
    cand_mask      = '0;
    match_pos      = '0;
    for (int i = 0; i < KeyRegs; i++) key_word[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (i == KeysRow) begin
        quiesce();
        write_key_reg(CfgKeyCount, 64'd7);  // saturates to all four keys
        write_key_reg(CfgKeyWord0, 64'h7861);
        write_key_reg(CfgKeyWord0 + CfgIdxW'(1), 64'h6261);
        write_key_reg(CfgKeyWord0 + CfgIdxW'(2), '1);
        write_key_reg(CfgKeyWord0 + CfgIdxW'(3), '0);
        write_key_reg(CfgIdxSpare, '1);
        write_key_reg(CfgIdxTop, 64'h6261);
        @(negedge clk_i);
      end
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end
    quiesce();

    run_phase(3'd4, 1'b0);
    run_phase(3'd1, 1'b0);
    run_phase(3'd0, 1'b0);
    run_phase(3'd7, 1'b1);
    run_phase(3'd2, 1'b0);
    run_phase(3'd3, 1'b0);

    if (err_count == 0) $display("[multi_keyword_prefix_matcher_core] OK");
    else $display("[multi_keyword_prefix_matcher_core] ERROR");
    $finish;
  end

endmodule
